// ===== rtl/vcsc_pkg.sv =====
`default_nettype none
package vcsc_pkg;

  // Field widths fixed by the interface
  localparam int VOLT_W     = 16;
  localparam int FRAC_W     = 13;
  localparam int GAIN_W     = 14;
  localparam int CEIL_W     = 15;
  localparam int SOFT_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed point constants
  localparam int UNITY     = 4096;
  localparam int TEN_VOLTS = 20480;
  localparam int X_LIMIT   = 12288;

  // Divider shapes: first divider gives |x| (14 bits), second gives |y| (13 bits)
  localparam int XQ_W   = 14;
  localparam int YQ_W   = 13;
  localparam int YDEN_W = 31;

  // 27 in Q24, the constant term of the shaper polynomial
  localparam logic [YDEN_W-1:0] SHAPE_K = 31'd452984832;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KNOB_GAIN      = 3'd0,
    CFG_CLIP_CEILING   = 3'd1,
    CFG_CLIP_SOFTNESS  = 3'd2,
    CFG_EXP_MODE       = 3'd3,
    CFG_GAIN_CV_ON     = 3'd4,
    CFG_CEILING_CV_ON  = 3'd5,
    CFG_SOFTNESS_CV_ON = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic ws_zero;  // no soft range: hard clip
    logic neg;      // excess over the clean range is negative
    logic sat;      // normalised excess beyond the shaper limit
  } clip_flags_t;

  // CV clamped to 0..10 V as Q0.12 fraction: floor((2cv+5)/10) by reciprocal
  function automatic logic [FRAC_W-1:0] cv_fraction(input logic signed [VOLT_W-1:0] cv);
    logic [15:0] c;
    logic [16:0] n;
    logic [33:0] p;
    if (cv < 0) c = 16'd0;
    else if (cv > 16'sd20480) c = 16'd20480;
    else c = cv;
    n = {c, 1'b0} + 17'd5;
    p = n * 17'd52429;
    return p[31:19];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vcsc_exp_rom.sv =====
`default_nettype none
module vcsc_exp_rom #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [$clog2(DEPTH+1)-1:0] addr_a,
  input  wire logic [$clog2(DEPTH+1)-1:0] addr_b,
  output logic [vcsc_pkg::FRAC_W-1:0]     data_a,
  output logic [vcsc_pkg::FRAC_W-1:0]     data_b
);

  typedef logic [vcsc_pkg::FRAC_W-1:0] tab_t [DEPTH+1];

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned EXP_DEN = 64'd49 << 30;

  // (50^c - 1)/49 in Q0.12, 2^f by a power series of f*ln2
  function automatic tab_t build_table();
    tab_t t;
    longint unsigned e, k, f, u, term, sum, val, q;
    for (int i = 0; i <= DEPTH; i++) begin
      e = (64'(i) * 64'd369876 + 64'(DEPTH / 2)) / 64'(DEPTH);
      k = e >> 16;
      f = e & 64'hFFFF;
      u = (f * 64'd744261118) >> 16;
      term = ONE_Q30;
      sum  = ONE_Q30;
      term = ((term * u) >> 30) / 64'd1;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd2;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd3;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd4;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd5;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd6;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd7;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd8;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd9;  sum = sum + term;
      term = ((term * u) >> 30) / 64'd10; sum = sum + term;
      term = ((term * u) >> 30) / 64'd11; sum = sum + term;
      term = ((term * u) >> 30) / 64'd12; sum = sum + term;
      term = ((term * u) >> 30) / 64'd13; sum = sum + term;
      term = ((term * u) >> 30) / 64'd14; sum = sum + term;
      val = sum << k;
      q = 64'd0;
      if (val > ONE_Q30) q = ((val - ONE_Q30) * 64'd4096 + EXP_DEN / 2) / EXP_DEN;
      if (q > 64'd4096) q = 64'd4096;
      t[i] = q[vcsc_pkg::FRAC_W-1:0];
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_table();

  // two registered read ports
  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= EXP_TAB[addr_a];
      data_b <= EXP_TAB[addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vcsc_front.sv =====
`default_nettype none
module vcsc_front #(
  parameter int SAMPLE_BITS     = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]    sample_in,
  input  wire logic signed [15:0]               gain_cv,
  input  wire logic signed [15:0]               ceiling_cv,
  input  wire logic signed [15:0]               softness_cv,
  input  wire logic [vcsc_pkg::GAIN_W-1:0]      knob_gain,
  input  wire logic [vcsc_pkg::CEIL_W-1:0]      clip_ceiling,
  input  wire logic [vcsc_pkg::SOFT_W-1:0]      clip_softness,
  input  wire logic                             exp_mode,
  input  wire logic                             gain_cv_on,
  input  wire logic                             ceiling_cv_on,
  input  wire logic                             softness_cv_on,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [SAMPLE_BITS+2:0]         out_v,
  output logic signed [SAMPLE_BITS+2:0]         out_clean,
  output logic [vcsc_pkg::CEIL_W-1:0]           out_ws_r,
  output vcsc_pkg::clip_flags_t                 out_flags,
  output logic [vcsc_pkg::CEIL_W-1:0]           out_num_hi,
  output logic [vcsc_pkg::XQ_W-1:0]             out_num_lo
);

  localparam int NS  = 7;
  localparam int VW  = SAMPLE_BITS + 3;
  localparam int PW  = SAMPLE_BITS + 15;
  localparam int MW  = VW + 14;
  localparam int EW  = VW + 2;
  localparam int NW  = VW + 14;
  localparam int FW  = vcsc_pkg::FRAC_W;
  localparam int CW  = vcsc_pkg::CEIL_W;
  localparam int AW  = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PSW = FW + AW;
  localparam logic [AW-1:0] LAST = AW'(EXP_TABLE_DEPTH);

  // stage valids and load enables
  logic [NS:1]   vld;
  logic [NS+1:1] en;

  assign en[NS+1]  = out_ready;
  assign in_ready  = en[1];
  assign out_valid = vld[NS];

  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: knob gain product, CV fractions
  logic signed [PW-1:0] p1;
  logic [FW-1:0]        gf1, cf1, sf1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1  <= $signed(sample_in) * $signed({1'b0, knob_gain});
      gf1 <= vcsc_pkg::cv_fraction(gain_cv);
      cf1 <= vcsc_pkg::cv_fraction(ceiling_cv);
      sf1 <= vcsc_pkg::cv_fraction(softness_cv);
    end
  end

  // stage 2: round knob gain, ceiling and softness products, table read
  localparam int SOFT_CW = vcsc_pkg::SOFT_W;

  logic [PW-1:0]         mag1, rnd1;
  logic [VW-1:0]         vmag1;
  logic [SOFT_CW-1:0]    soft_c;
  logic [PSW-1:0]        pos1;
  logic [AW-1:0]         adr_a, adr_b;

  always_comb begin
    mag1   = p1[PW-1] ? (~p1 + 1'b1) : p1;
    rnd1   = (mag1 + PW'(2048)) >> 12;
    vmag1  = rnd1[VW-1:0];
    soft_c = (clip_softness > 13'd4096) ? 13'd4096 : clip_softness;
    pos1   = PSW'(gf1) * PSW'(EXP_TABLE_DEPTH);
    adr_a  = pos1[PSW-2:12];
    adr_b  = (adr_a == LAST) ? adr_a : adr_a + 1'b1;
  end

  logic signed [VW-1:0] v0_2;
  logic [CW+FW-1:0]     cp2;
  logic [2*FW-1:0]      sp2;
  logic [SOFT_CW-1:0]   sc2;
  logic [FW-1:0]        gf2;
  logic [11:0]          fr2;
  logic [FW-1:0]        ra2, rb2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v0_2 <= p1[PW-1] ? (~vmag1 + 1'b1) : vmag1;
      cp2  <= clip_ceiling * cf1;
      sp2  <= soft_c * sf1;
      sc2  <= soft_c;
      gf2  <= gf1;
      fr2  <= pos1[11:0];
    end
  end

  vcsc_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (
    .clk   (clk),
    .en    (en[2]),
    .addr_a(adr_a),
    .addr_b(adr_b),
    .data_a(ra2),
    .data_b(rb2)
  );

  // stage 3: effective ceiling and softness, interpolation product
  logic [CW+FW-1:0] cpr2;
  logic [2*FW-1:0]  spr2;
  logic [FW-1:0]    diff2;

  always_comb begin
    cpr2  = (cp2 + (CW+FW)'(2048)) >> 12;
    spr2  = (sp2 + (2*FW)'(2048)) >> 12;
    diff2 = (rb2 < ra2) ? '0 : rb2 - ra2;
  end

  logic signed [VW-1:0] v0_3;
  logic [CW-1:0]        ceil3;
  logic [FW-1:0]        soft3, gf3, a3;
  logic [FW+11:0]       ip3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      v0_3  <= v0_2;
      ceil3 <= ceiling_cv_on ? cpr2[CW-1:0] : clip_ceiling;
      soft3 <= softness_cv_on ? spr2[FW-1:0] : sc2;
      gf3   <= gf2;
      a3    <= ra2;
      ip3   <= diff2 * fr2;
    end
  end

  // stage 4: gain fraction, clean range product
  logic [FW+11:0] ipr3;
  assign ipr3 = (ip3 + (FW+12)'(2048)) >> 12;

  logic signed [VW-1:0] v0_4;
  logic [FW-1:0]        g4;
  logic [CW-1:0]        ceil4;
  logic [CW+FW-1:0]     cp4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      v0_4  <= v0_3;
      g4    <= exp_mode ? a3 + ipr3[FW-1:0] : gf3;
      ceil4 <= ceil3;
      cp4   <= ceil3 * (13'd4096 - soft3);
    end
  end

  // stage 5: gain CV product, range split
  logic [CW+FW-1:0] cpr4;
  assign cpr4 = (cp4 + (CW+FW)'(2048)) >> 12;

  logic signed [VW-1:0] v0_5;
  logic signed [MW-1:0] vp5;
  logic [CW-1:0]        cr5, ws5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      v0_5 <= v0_4;
      vp5  <= $signed(v0_4) * $signed({1'b0, g4});
      cr5  <= cpr4[CW-1:0];
      ws5  <= ceil4 - cpr4[CW-1:0];
    end
  end

  // stage 6: round gain CV product
  logic [MW-1:0] mag5, rnd5;
  logic [VW-1:0] vm5;

  always_comb begin
    mag5 = vp5[MW-1] ? (~vp5 + 1'b1) : vp5;
    rnd5 = (mag5 + MW'(2048)) >> 12;
    vm5  = rnd5[VW-1:0];
  end

  logic signed [VW-1:0] v6;
  logic [CW-1:0]        cr6, ws6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      v6  <= gain_cv_on ? (vp5[MW-1] ? (~vm5 + 1'b1) : vm5) : v0_5;
      cr6 <= cr5;
      ws6 <= ws5;
    end
  end

  // stage 7: clean part, excess and divider operands
  logic signed [EW-1:0] ve, cre, ncr, cln, dd;
  logic [EW-1:0]        dm;
  logic [NW-1:0]        nn, lim;
  logic                 sat;

  always_comb begin
    ve  = {{2{v6[VW-1]}}, v6};
    cre = {{(EW-CW){1'b0}}, cr6};
    ncr = -cre;
    if (ve > cre) cln = cre;
    else if (ve < ncr) cln = ncr;
    else cln = ve;
    dd  = ve - cln;
    dm  = dd[EW-1] ? (~dd + 1'b1) : dd;
    nn  = NW'({dm[VW-1:0], 12'b0}) + NW'(ws6 >> 1);
    lim = NW'(ws6) << 14;
    sat = nn >= lim;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_v             <= v6;
      out_clean         <= cln[VW-1:0];
      out_ws_r          <= ws6;
      out_flags.ws_zero <= (ws6 == '0);
      out_flags.neg     <= dd[EW-1];
      out_flags.sat     <= sat;
      out_num_hi        <= sat ? '0 : nn[CW+13:14];
      out_num_lo        <= nn[13:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vcsc_div.sv =====
`default_nettype none
module vcsc_div #(
  parameter int DEN_W  = 15,
  parameter int Q_W    = 14,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DEN_W-1:0]  num_hi,   // must be below den
  input  wire logic [Q_W-1:0]    num_lo,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [Q_W-1:0]         quot,
  output logic [SIDE_W-1:0]      side_out
);

  // one quotient bit per stage, restoring
  logic [Q_W:1]         vld;
  logic [Q_W+1:1]       en;
  logic [DEN_W-1:0]     rem  [1:Q_W];
  logic [Q_W-1:0]       qt   [1:Q_W];
  logic [Q_W-1:0]       low  [1:Q_W];
  logic [DEN_W-1:0]     dv   [1:Q_W];
  logic [SIDE_W-1:0]    sd   [1:Q_W];

  assign en[Q_W+1] = out_ready;
  assign in_ready  = en[1];
  assign out_valid = vld[Q_W];
  assign quot      = qt[Q_W];
  assign side_out  = sd[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= Q_W; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rp, dp;
    logic [Q_W-1:0]    qp, lp;
    logic [SIDE_W-1:0] sp;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 1) begin : g_first
      assign rp = num_hi;
      assign qp = '0;
      assign lp = num_lo;
      assign dp = den;
      assign sp = side_in;
    end else begin : g_next
      assign rp = rem[k-1];
      assign qp = qt[k-1];
      assign lp = low[k-1];
      assign dp = dv[k-1];
      assign sp = sd[k-1];
    end

    assign en[k] = !vld[k] || en[k+1];
    assign trial = {rp, lp[Q_W-1]};
    assign ge    = trial >= {1'b0, dp};

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k] <= ge ? DEN_W'(trial - {1'b0, dp}) : trial[DEN_W-1:0];
        qt[k]  <= {qp[Q_W-2:0], ge};
        low[k] <= lp << 1;
        dv[k]  <= dp;
        sd[k]  <= sp;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vcsc_shape.sv =====
`default_nettype none
module vcsc_shape #(
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vcsc_pkg::XQ_W-1:0]     xq,
  input  wire vcsc_pkg::clip_flags_t         flags_in,
  input  wire logic [SIDE_W-1:0]             side_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vcsc_pkg::YDEN_W-1:0]        num_hi,
  output logic [vcsc_pkg::YQ_W-1:0]          num_lo,
  output logic [vcsc_pkg::YDEN_W-1:0]        den,
  output vcsc_pkg::clip_flags_t              flags_out,
  output logic [SIDE_W-1:0]                  side_out
);

  localparam int NS = 3;
  localparam int XW = vcsc_pkg::XQ_W;
  localparam int DW = vcsc_pkg::YDEN_W;
  localparam int PW = XW + DW;

  logic [NS:1]   vld;
  logic [NS+1:1] en;

  assign en[NS+1]  = out_ready;
  assign in_ready  = en[1];
  assign out_valid = vld[NS];

  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: clamp |x| to three, square
  logic [XW-1:0]             xm;
  logic [XW-1:0]             x1;
  logic [2*XW-1:0]           x2;
  vcsc_pkg::clip_flags_t     f1, f2;
  logic [SIDE_W-1:0]         s1, s2;

  assign xm = (flags_in.sat || xq > XW'(vcsc_pkg::X_LIMIT)) ? XW'(vcsc_pkg::X_LIMIT) : xq;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= xm;
      x2 <= xm * xm;
      f1 <= flags_in;
      s1 <= side_in;
    end
  end

  // stage 2: numerator x(27+x^2), denominator 27+9x^2
  logic [DW-1:0] cpoly;
  logic [PW-1:0] np2;
  logic [DW-1:0] d2;

  assign cpoly = vcsc_pkg::SHAPE_K + DW'(x2);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      np2 <= PW'(x1) * PW'(cpoly);
      d2  <= vcsc_pkg::SHAPE_K + DW'(x2) * DW'(9);
      f2  <= f1;
      s2  <= s1;
    end
  end

  // stage 3: add half the divisor for rounding, split for the divider
  logic [PW:0] nr;
  assign nr = {1'b0, np2} + (PW+1)'(d2 >> 1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      num_hi    <= nr[DW+12:13];
      num_lo    <= nr[12:0];
      den       <= d2;
      flags_out <= f2;
      side_out  <= s2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vcsc_out.sv =====
`default_nettype none
module vcsc_out #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vcsc_pkg::YQ_W-1:0]     yq,
  input  wire vcsc_pkg::clip_flags_t         flags,
  input  wire logic signed [SAMPLE_BITS+2:0] v,
  input  wire logic signed [SAMPLE_BITS+2:0] clean,
  input  wire logic [vcsc_pkg::CEIL_W-1:0]   ws_r,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic signed [SAMPLE_BITS+1:0]      clip_excess
);

  localparam int NS = 2;
  localparam int VW = SAMPLE_BITS + 3;
  localparam int EW = VW + 2;
  localparam int MW = vcsc_pkg::YQ_W + vcsc_pkg::CEIL_W;
  localparam logic signed [EW-1:0] SMAX = EW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

  logic [NS:1]   vld;
  logic [NS+1:1] en;

  assign en[NS+1]  = out_ready;
  assign in_ready  = en[1];
  assign out_valid = vld[NS];

  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= in_valid;
      if (en[2]) vld[2] <= vld[1];
    end
  end

  // stage 1: shaped value back to volts
  logic [MW-1:0]        m1;
  logic                 neg1, wz1;
  logic signed [VW-1:0] v1, c1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1   <= yq * ws_r;
      neg1 <= flags.neg;
      wz1  <= flags.ws_zero;
      v1   <= v;
      c1   <= clean;
    end
  end

  // stage 2: add to clean part, saturate, excess
  logic [MW-1:0]        mr;
  logic [15:0]          wp;
  logic signed [EW-1:0] ce, we, sum, res, ve, ex;

  always_comb begin
    mr  = (m1 + MW'(2048)) >> 12;
    wp  = wz1 ? '0 : mr[15:0];
    ce  = {{2{c1[VW-1]}}, c1};
    we  = EW'(wp);
    sum = neg1 ? ce - we : ce + we;
    if (sum > SMAX) res = SMAX;
    else if (sum < SMIN) res = SMIN;
    else res = sum;
    ve  = {{2{v1[VW-1]}}, v1};
    ex  = ve - res;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sample_out  <= res[SAMPLE_BITS-1:0];
      clip_excess <= ex[SAMPLE_BITS+1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vca_soft_clipper_unit.sv =====
`default_nettype none
// Soft clipping VCA, fully pipelined: one item per clock sustained while m_tready is high.
// From input accept to result valid an item passes 7 front stages, a 14-stage
// divider for the normalised excess, 3 shaper stages, a 13-stage divider for the
// shaper quotient and 2 output stages. Backpressure stalls stage by stage.
// Synchronous reset clears the pipeline valids and loads the register defaults.
module vca_soft_clipper_unit #(
  parameter int SAMPLE_BITS     = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // sample_in, gain_cv, ceiling_cv, softness_cv
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SAMPLE_BITS+48+7)/8)*8-1:0]   s_tdata,
  // sample_out, clip_excess
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]       m_tdata,
  // register writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [vcsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [vcsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int S      = SAMPLE_BITS;
  localparam int VW     = S + 3;
  localparam int CW     = vcsc_pkg::CEIL_W;
  localparam int FL_W   = $bits(vcsc_pkg::clip_flags_t);
  localparam int SIDE_W = 2 * VW + CW;
  localparam int OUT_TW = ((2*S+2+7)/8)*8;

  // configuration registers
  logic [vcsc_pkg::GAIN_W-1:0] knob_gain;
  logic [CW-1:0]               clip_ceiling;
  logic [vcsc_pkg::SOFT_W-1:0] clip_softness;
  logic                        exp_mode, gain_cv_on, ceiling_cv_on, softness_cv_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knob_gain      <= 14'd4096;
      clip_ceiling   <= 15'd10240;
      clip_softness  <= 13'd2048;
      exp_mode       <= 1'b0;
      gain_cv_on     <= 1'b0;
      ceiling_cv_on  <= 1'b0;
      softness_cv_on <= 1'b0;
    end else if (cfg_valid) begin
      unique case (vcsc_pkg::cfg_index_t'(cfg_index))
        vcsc_pkg::CFG_KNOB_GAIN:      knob_gain      <= cfg_data[vcsc_pkg::GAIN_W-1:0];
        vcsc_pkg::CFG_CLIP_CEILING:   clip_ceiling   <= cfg_data[CW-1:0];
        vcsc_pkg::CFG_CLIP_SOFTNESS:  clip_softness  <= cfg_data[vcsc_pkg::SOFT_W-1:0];
        vcsc_pkg::CFG_EXP_MODE:       exp_mode       <= cfg_data[0];
        vcsc_pkg::CFG_GAIN_CV_ON:     gain_cv_on     <= cfg_data[0];
        vcsc_pkg::CFG_CEILING_CV_ON:  ceiling_cv_on  <= cfg_data[0];
        vcsc_pkg::CFG_SOFTNESS_CV_ON: softness_cv_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: gains, ranges, clean part
  logic                  fr_valid, fr_ready;
  logic signed [VW-1:0]  fr_v, fr_clean;
  logic [CW-1:0]         fr_ws, fr_hi;
  logic [vcsc_pkg::XQ_W-1:0] fr_lo;
  vcsc_pkg::clip_flags_t fr_flags;

  vcsc_front #(.SAMPLE_BITS(S), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .sample_in     (s_tdata[S-1:0]),
    .gain_cv       (s_tdata[S+15:S]),
    .ceiling_cv    (s_tdata[S+31:S+16]),
    .softness_cv   (s_tdata[S+47:S+32]),
    .knob_gain     (knob_gain),
    .clip_ceiling  (clip_ceiling),
    .clip_softness (clip_softness),
    .exp_mode      (exp_mode),
    .gain_cv_on    (gain_cv_on),
    .ceiling_cv_on (ceiling_cv_on),
    .softness_cv_on(softness_cv_on),
    .out_valid     (fr_valid),
    .out_ready     (fr_ready),
    .out_v         (fr_v),
    .out_clean     (fr_clean),
    .out_ws_r      (fr_ws),
    .out_flags     (fr_flags),
    .out_num_hi    (fr_hi),
    .out_num_lo    (fr_lo)
  );

  // excess over the clean range, normalised to the soft range
  logic                       d1_valid, d1_ready;
  logic [vcsc_pkg::XQ_W-1:0]  d1_q;
  logic [FL_W+SIDE_W-1:0]     d1_side;

  vcsc_div #(.DEN_W(CW), .Q_W(vcsc_pkg::XQ_W), .SIDE_W(FL_W + SIDE_W)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .in_ready (fr_ready),
    .num_hi   (fr_hi),
    .num_lo   (fr_lo),
    .den      (fr_ws),
    .side_in  ({fr_flags, fr_ws, fr_clean, fr_v}),
    .out_valid(d1_valid),
    .out_ready(d1_ready),
    .quot     (d1_q),
    .side_out (d1_side)
  );

  // shaper polynomial
  logic                        sh_valid, sh_ready;
  logic [vcsc_pkg::YDEN_W-1:0] sh_hi, sh_den;
  logic [vcsc_pkg::YQ_W-1:0]   sh_lo;
  vcsc_pkg::clip_flags_t       sh_flags;
  logic [SIDE_W-1:0]           sh_side;

  vcsc_shape #(.SIDE_W(SIDE_W)) u_shape (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d1_valid),
    .in_ready (d1_ready),
    .xq       (d1_q),
    .flags_in (vcsc_pkg::clip_flags_t'(d1_side[FL_W+SIDE_W-1:SIDE_W])),
    .side_in  (d1_side[SIDE_W-1:0]),
    .out_valid(sh_valid),
    .out_ready(sh_ready),
    .num_hi   (sh_hi),
    .num_lo   (sh_lo),
    .den      (sh_den),
    .flags_out(sh_flags),
    .side_out (sh_side)
  );

  // shaper quotient
  logic                      d2_valid, d2_ready;
  logic [vcsc_pkg::YQ_W-1:0] d2_q;
  logic [FL_W+SIDE_W-1:0]    d2_side;

  vcsc_div #(.DEN_W(vcsc_pkg::YDEN_W), .Q_W(vcsc_pkg::YQ_W), .SIDE_W(FL_W + SIDE_W)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sh_valid),
    .in_ready (sh_ready),
    .num_hi   (sh_hi),
    .num_lo   (sh_lo),
    .den      (sh_den),
    .side_in  ({sh_flags, sh_side}),
    .out_valid(d2_valid),
    .out_ready(d2_ready),
    .quot     (d2_q),
    .side_out (d2_side)
  );

  // rescale, sum, saturate
  logic signed [S-1:0] sample_out;
  logic signed [S+1:0] clip_excess;

  vcsc_out #(.SAMPLE_BITS(S)) u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d2_valid),
    .in_ready   (d2_ready),
    .yq         (d2_q),
    .flags      (vcsc_pkg::clip_flags_t'(d2_side[FL_W+SIDE_W-1:SIDE_W])),
    .v          (d2_side[VW-1:0]),
    .clean      (d2_side[2*VW-1:VW]),
    .ws_r       (d2_side[SIDE_W-1:2*VW]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (sample_out),
    .clip_excess(clip_excess)
  );

  assign m_tdata = OUT_TW'({clip_excess, sample_out});

endmodule
`default_nettype wire

// ===== bench/vca_soft_clipper_unit_tb.sv =====
module vca_soft_clipper_unit_tb;

  localparam int PIPE_LAT   = 39;
  localparam int STALL_LIMIT = 3000;
  localparam int N_RANDOM   = 1300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // sample_in, gain_cv, ceiling_cv, softness_cv
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // sample_out, clip_excess, zero pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  vcsc_pkg::cfg_index_t cfg_index = vcsc_pkg::CFG_KNOB_GAIN;
  logic [15:0] cfg_data = '0;

  vca_soft_clipper_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic signed [15:0] shaped;
    logic signed [17:0] excess;
  } clip_result_t;

  typedef struct {
    int preset;
    logic signed [15:0] smp, gcv, ccv, scv;
    bit typed;
    logic signed [15:0] shaped;
    logic signed [17:0] excess;
  } stim_row_t;

  // register images as the block should hold them
  logic [13:0] knob_gain_r;
  logic [14:0] ceiling_r;
  logic [12:0] softness_r;
  logic        exp_mode_r, gain_cv_r, ceil_cv_r, soft_cv_r;

  longint unsigned exp_curve [0:256];
  clip_result_t    pending_q[$];
  int              n_errors = 0;
  int              n_sent = 0;
  int              n_checked = 0;
  int              n_clipped = 0;
  int              n_cfg = 0;
  bit              calm = 1'b0;
  bit              stim_done = 1'b0;
  bit              row_typed = 1'b0;
  clip_result_t    row_result;
  int              idle_cycles = 0;

  // presets: gain, ceiling, softness, exp, gain cv, ceiling cv, softness cv
  int presets [0:4][0:6] = '{
    '{4096, 10240, 2048, 0, 0, 0, 0},
    '{4096, 10240, 0, 0, 0, 0, 0},
    '{8192, 32767, 8191, 1, 1, 1, 1},
    '{0, 0, 4096, 0, 1, 0, 0},
    '{16383, 20480, 4096, 1, 1, 1, 1}
  };

  stim_row_t rows [0:16] = '{
    '{0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd0, 18'sd0},
    '{0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd1000, 18'sd0},
    '{0, 16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd10240, 18'sd22527},
    '{0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1, -16'sd10240, -18'sd22528},
    '{0, 16'sd6000, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 18'sd0},
    '{0, -16'sd7000, 16'sd0, 16'sd0, 16'sd0, 0, 16'sd0, 18'sd0},
    '{1, 16'sd20000, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd10240, 18'sd9760},
    '{1, -16'sd20000, 16'sd0, 16'sd0, 16'sd0, 1, -16'sd10240, -18'sd9760},
    '{1, 16'sd5000, 16'sd0, 16'sd0, 16'sd0, 1, 16'sd5000, 18'sd0},
    '{2, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd20480, 0, 16'sd0, 18'sd0},
    '{2, -16'sd32768, 16'sd20480, 16'sd32767, -16'sd1, 0, 16'sd0, 18'sd0},
    '{2, 16'sd12345, 16'sd10240, 16'sd10240, 16'sd10240, 0, 16'sd0, 18'sd0},
    '{2, 16'sd30000, 16'sd1, 16'sd20479, 16'sd1, 0, 16'sd0, 18'sd0},
    '{3, 16'sd32767, 16'sd20480, 16'sd0, 16'sd0, 1, 16'sd0, 18'sd0},
    '{3, -16'sd32768, 16'sd20480, 16'sd0, 16'sd0, 1, 16'sd0, 18'sd0},
    '{4, 16'sd32767, 16'sd20480, 16'sd20480, 16'sd20480, 0, 16'sd0, 18'sd0},
    '{4, -16'sd32768, 16'sd20479, 16'sd2048, 16'sd4096, 0, 16'sd0, 18'sd0}
  };

  function automatic longint rnd_away(longint a, longint d);
    if (a >= 0) return (a + d / 2) / d;
    return -((-a + d / 2) / d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint volts_to_frac(logic signed [15:0] cv);
    longint c;
    c = clamp(longint'(cv), 0, 20480);
    return rnd_away(c * 4096, 20480);
  endfunction

  // 2^f, f in Q16, result Q30, Taylor series of exp(f ln2)
  function automatic longint unsigned pow2_q30(longint unsigned f16);
    longint unsigned u, acc, term;
    u = (f16 * 64'd744261118) >> 16;
    acc = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * u) >> 30) / n;
      acc += term;
    end
    return acc;
  endfunction

  // (50^c - 1)/49 curve at 257 points, Q0.12
  function automatic void fill_exp_curve();
    longint unsigned e, val, q, one, den;
    one = 64'd1 << 30;
    den = 64'd49 * one;
    for (int i = 0; i <= 256; i++) begin
      e = (longint'(i) * 369876 + 128) / 256;
      val = pow2_q30(e & 64'hFFFF) << (e >> 16);
      q = 0;
      if (val > one) q = ((val - one) * 4096 + den / 2) / den;
      if (q > 4096) q = 4096;
      exp_curve[i] = q;
    end
  endfunction

  function automatic longint exp_gain(longint c12);
    longint unsigned pos, idx, frac, a, b;
    pos = c12 * 256;
    idx = pos / 4096;
    frac = pos % 4096;
    if (idx >= 256) return exp_curve[256];
    a = exp_curve[idx];
    b = exp_curve[idx + 1];
    if (b < a) b = a;
    return a + (((b - a) * frac + 2048) >> 12);
  endfunction

  function automatic longint shaper(longint x);
    longint x2, num, den;
    x = clamp(x, -12288, 12288);
    x2 = x * x;
    num = x * (27 * (64'sd1 << 24) + x2);
    den = 27 * (64'sd1 << 24) + 9 * x2;
    return rnd_away(num, den);
  endfunction

  function automatic clip_result_t clip_sample(logic [63:0] d);
    clip_result_t r;
    longint v, ceil_v, soft_v, clean_r, ws_r, clean_v, ws_part, res;
    v = rnd_away(longint'($signed(d[15:0])) * knob_gain_r, 4096);
    if (gain_cv_r) begin
      ceil_v = volts_to_frac(d[31:16]);
      if (exp_mode_r) ceil_v = exp_gain(ceil_v);
      v = rnd_away(v * ceil_v, 4096);
    end
    ceil_v = ceiling_r;
    if (ceil_cv_r) ceil_v = rnd_away(ceil_v * volts_to_frac(d[47:32]), 4096);
    soft_v = softness_r > 4096 ? 4096 : softness_r;
    if (soft_cv_r) soft_v = rnd_away(soft_v * volts_to_frac(d[63:48]), 4096);
    clean_r = rnd_away(ceil_v * (4096 - soft_v), 4096);
    ws_r = ceil_v - clean_r;
    clean_v = clamp(v, -clean_r, clean_r);
    ws_part = 0;
    // zero soft range falls back to a hard clip
    if (ws_r > 0) ws_part = rnd_away(shaper(rnd_away((v - clean_v) * 4096, ws_r)) * ws_r, 4096);
    res = clamp(clean_v + ws_part, -32768, 32767);
    r.shaped = res[15:0];
    r.excess = 18'(v - res);
    return r;
  endfunction

  // monitor: register writes, accepted items, results
  always @(posedge clk) begin
    clip_result_t want;
    logic signed [15:0] got_s;
    logic signed [17:0] got_e;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        n_cfg++;
        case (cfg_index)
          vcsc_pkg::CFG_KNOB_GAIN:      knob_gain_r = cfg_data[13:0];
          vcsc_pkg::CFG_CLIP_CEILING:   ceiling_r = cfg_data[14:0];
          vcsc_pkg::CFG_CLIP_SOFTNESS:  softness_r = cfg_data[12:0];
          vcsc_pkg::CFG_EXP_MODE:       exp_mode_r = cfg_data[0];
          vcsc_pkg::CFG_GAIN_CV_ON:     gain_cv_r = cfg_data[0];
          vcsc_pkg::CFG_CEILING_CV_ON:  ceil_cv_r = cfg_data[0];
          vcsc_pkg::CFG_SOFTNESS_CV_ON: soft_cv_r = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        n_sent++;
        pending_q.push_back(row_typed ? row_result : clip_sample(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got_s = m_tdata[15:0];
        got_e = m_tdata[33:16];
        if (pending_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected item s=%0d e=%0d", $time, got_s, got_e);
        end else begin
          want = pending_q.pop_front();
          n_checked++;
          if (got_e != 0) n_clipped++;
          if (got_s != want.shaped) begin
            n_errors++;
            $display("%0t: sample_out exp %0d got %0d", $time, want.shaped, got_s);
          end
          if (got_e != want.excess) begin
            n_errors++;
            $display("%0t: clip_excess exp %0d got %0d", $time, want.excess, got_e);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: stalled, %0d items outstanding", $time, pending_q.size());
        $display("vca_soft_clipper_unit_tb: errors");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off, a calm stretch
  initial begin
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 300) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 6) @(posedge clk);
  endtask

  task automatic write_regs(int g, int c, int s, int e, int gon, int con, int son);
    int vals [0:6];
    vals = '{g, c, s, e, gon, con, son};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= vcsc_pkg::cfg_index_t'(i);
      cfg_data  <= 16'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic [63:0] d, bit typed, clip_result_t r);
    while (!calm && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= d;
    row_typed  <= typed;
    row_result <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_cv();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd20480;
      2: return 16'd0;
      default: return 16'($urandom_range(0, 20480));
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed(16'($urandom_range(0, 4095))) - 16'sd2048);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int cur;
    int phase_len;
    clip_result_t r;
    fill_exp_curve();
    knob_gain_r = 14'd4096;
    ceiling_r = 15'd10240;
    softness_r = 13'd2048;
    {exp_mode_r, gain_cv_r, ceil_cv_r, soft_cv_r} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, preset reloaded whenever it changes
    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].preset != cur) begin
        s_tvalid <= 1'b0;
        cur = rows[i].preset;
        write_regs(presets[cur][0], presets[cur][1], presets[cur][2], presets[cur][3],
                   presets[cur][4], presets[cur][5], presets[cur][6]);
      end
      r.shaped = rows[i].shaped;
      r.excess = rows[i].excess;
      send_item({rows[i].scv, rows[i].ccv, rows[i].gcv, rows[i].smp}, rows[i].typed, r);
    end

    // random phases: fixed register settings in the first and last, random ones between
    for (int ph = 0; ph < 10; ph++) begin
      s_tvalid <= 1'b0;
      if (ph == 0)
        write_regs(4096, 10240, 2048, 0, 0, 0, 0);
      else if (ph == 9)
        write_regs(16383, 32767, 0, 1, 1, 1, 1);
      else
        write_regs($urandom_range(0, 1) ? $urandom_range(0, 16383) : 8192,
                   $urandom_range(0, 3) ? $urandom_range(0, 20480) : $urandom_range(0, 32767),
                   $urandom_range(0, 3) ? $urandom_range(0, 4096) : $urandom_range(0, 8191),
                   $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
      calm = (ph == 4);
      phase_len = N_RANDOM / 10;
      for (int k = 0; k < phase_len; k++)
        send_item({rand_cv(), rand_cv(), rand_cv(), rand_sample()}, 1'b0, r);
      calm = 1'b0;
    end
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 6) @(posedge clk);
    $display("%0d items checked over %0d register writes, %0d with clipping",
             n_checked, n_cfg, n_clipped);
    $display("covered hard clip, softness saturation, exp and linear gain CV, long stall");
    if (n_errors == 0)
      $display("vca_soft_clipper_unit_tb: clean");
    else
      $display("vca_soft_clipper_unit_tb: errors");
    $finish;
  end

endmodule
